>>> sv/knn_top_k_search_defines.svh
// ---------------------------------------------------------------------------
// knn_top_k_search assertion macros
// Shared concurrent assertion forms used by the k-nearest search block.
// ---------------------------------------------------------------------------
`ifndef KNN_TOP_K_SEARCH_DEFINES_SVH
`define KNN_TOP_K_SEARCH_DEFINES_SVH

// cur may only be high in the cycle after prev was high
`define KNN_ASSERT_AFTER(label, cur, prev, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cur) |-> $past(prev)) \
        else $error(msg);

// cause implies effect on the following cycle
`define KNN_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

>>> sv/knn_pkg.sv
// ---------------------------------------------------------------------------
// knn_pkg
// Types, codes and constants shared by the k-nearest search block.
// ---------------------------------------------------------------------------
package knn_pkg;

    // default sizes
    localparam int DEF_MAX_DIM        = 64;
    localparam int DEF_MAX_NEIGHBOURS = 16;
    localparam int DEF_MAX_CANDIDATES = 65536;
    localparam int DEF_COORD_BITS     = 16;

    // fixed field widths
    localparam int REQ_W      = 2;
    localparam int RANK_W     = 4;
    localparam int INDEX_W    = 16;
    localparam int DIST_W     = 38;
    localparam int SQ_OP_W    = DIST_W / 2;
    localparam int DIM_REG_W  = 7;
    localparam int K_REG_W    = 5;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DIST_W-1:0]    DIST_SAT  = '1;
    localparam logic [DIM_REG_W-1:0] DIM_RESET = 7'd2;
    localparam logic [K_REG_W-1:0]   K_RESET   = 5'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOURS = 1'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_QUERY  = 2'd0,
        REQ_CAND   = 2'd1,
        REQ_FINISH = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_INSERT,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic query_wr;     // store query coordinate, advance position
        logic cand_rd;      // latch candidate coordinate, read query entry
        logic square;       // difference and square
        logic accum;        // add into running distance
        logic insert;       // sorted insertion of the finished candidate
        logic report_load;  // load one list slot into the output register
    } cmd_t;

    typedef struct packed {
        logic point_done;   // current coordinate completes a candidate
        logic cand_full;    // index limit reached
        logic report_last;  // slot being reported is the final one
        logic out_free;     // output register can take a beat
    } status_t;

endpackage

>>> sv/knn_top_k_search.sv
// ---------------------------------------------------------------------------
// knn_top_k_search
// Brute-force k-nearest search over a stream of candidate coordinates.
// ---------------------------------------------------------------------------
// Load a query point one coordinate at a time (req_type 0), then stream
// candidate coordinates (req_type 1); every dimension coordinates close one
// candidate, numbered from 0 in arrival order, whose exact squared distance
// enters a sorted list of the nearest neighbours (ties keep the earlier
// candidate). A finish (req_type 2) sends neighbours beats, nearest first,
// with empty slots marked not found, then restarts the search against the
// same query. A query coordinate is stored as it is accepted; a candidate
// coordinate is accepted with the query memory read, then squared, then
// accumulated, and the last coordinate of a point adds the sorted
// insertion when the candidate limit is not reached; a finish loads one
// list slot per beat into the output register, held by any output stall.
// The single multiply-accumulate unit and the registered query memory read
// set these steps. Write configuration only while the block is idle.
// ---------------------------------------------------------------------------
`include "knn_top_k_search_defines.svh"

module knn_top_k_search
#(
    parameter int MAX_DIM        = knn_pkg::DEF_MAX_DIM,
    parameter int MAX_NEIGHBOURS = knn_pkg::DEF_MAX_NEIGHBOURS,
    parameter int MAX_CANDIDATES = knn_pkg::DEF_MAX_CANDIDATES,
    parameter int COORD_BITS     = knn_pkg::DEF_COORD_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [knn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [knn_pkg::REQ_W-1:0]           req_type,
    input  logic signed [COORD_BITS-1:0]        coord_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [knn_pkg::RANK_W-1:0]          rank,
    output logic [knn_pkg::INDEX_W-1:0]         neighbour_index,
    output logic [knn_pkg::DIST_W-1:0]          distance_sq,
    output logic                                found,
    output logic                                overflow,
    output logic                                last
);

    knn_pkg::cmd_t    cmd;
    knn_pkg::status_t status;

    knn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    knn_datapath
    #(
        .MAX_DIM        (MAX_DIM),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .COORD_BITS     (COORD_BITS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .coord_value     (coord_value),
        .cmd             (cmd),
        .out_stall       (out_stall),
        .status          (status),
        .out_valid       (out_valid),
        .rank            (rank),
        .neighbour_index (neighbour_index),
        .distance_sq     (distance_sq),
        .found           (found),
        .overflow        (overflow),
        .last            (last)
    );

    // squaring uses the query entry read on the accepting cycle
    `KNN_ASSERT_AFTER(a_square_after_read, cmd.square, cmd.cand_rd, "square without query read")
    // insertion only right after the accumulate step that closed the point
    `KNN_ASSERT_AFTER(a_insert_after_acc, cmd.insert, cmd.accum, "insert without accumulate")
    // the last report beat frees the input side on the next cycle
    `KNN_ASSERT_NEXT(a_idle_after_report, cmd.report_load && status.report_last, !in_stall, "report did not end")

endmodule

>>> sv/knn_ctrl.sv
// ---------------------------------------------------------------------------
// knn_ctrl
// Sequencer for the k-nearest search: accepts requests and steps the
// datapath through distance accumulation, insertion and report.
// ---------------------------------------------------------------------------
module knn_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [knn_pkg::REQ_W-1:0]     req_type,
    input  knn_pkg::status_t              status,
    output logic                          in_stall,
    output knn_pkg::cmd_t                 cmd
);

    knn_pkg::state_t state_reg;
    knn_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= knn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            knn_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (knn_pkg::req_t'(req_type))
                        knn_pkg::REQ_QUERY:
                        begin
                            cmd.query_wr = 1'b1;
                        end
                        knn_pkg::REQ_CAND:
                        begin
                            cmd.cand_rd = 1'b1;
                            state_next  = knn_pkg::ST_SQUARE;
                        end
                        knn_pkg::REQ_FINISH:
                        begin
                            state_next = knn_pkg::ST_REPORT;
                        end
                        default:
                        begin
                            // unused request code: dropped
                        end
                    endcase
                end
            end
            knn_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = knn_pkg::ST_ACCUM;
            end
            knn_pkg::ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (status.point_done && !status.cand_full)
                begin
                    state_next = knn_pkg::ST_INSERT;
                end
                else
                begin
                    state_next = knn_pkg::ST_IDLE;
                end
            end
            knn_pkg::ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = knn_pkg::ST_IDLE;
            end
            knn_pkg::ST_REPORT:
            begin
                if (status.out_free)
                begin
                    cmd.report_load = 1'b1;
                    if (status.report_last)
                    begin
                        state_next = knn_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = knn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/knn_datapath.sv
// ---------------------------------------------------------------------------
// knn_datapath
// Query store, squared-difference accumulator, sorted nearest list and
// result output register of the k-nearest search.
// ---------------------------------------------------------------------------
module knn_datapath
#(
    parameter int MAX_DIM        = knn_pkg::DEF_MAX_DIM,
    parameter int MAX_NEIGHBOURS = knn_pkg::DEF_MAX_NEIGHBOURS,
    parameter int MAX_CANDIDATES = knn_pkg::DEF_MAX_CANDIDATES,
    parameter int COORD_BITS     = knn_pkg::DEF_COORD_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [knn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [COORD_BITS-1:0]        coord_value,
    input  knn_pkg::cmd_t                       cmd,
    input  logic                                out_stall,
    output knn_pkg::status_t                    status,
    output logic                                out_valid,
    output logic [knn_pkg::RANK_W-1:0]          rank,
    output logic [knn_pkg::INDEX_W-1:0]         neighbour_index,
    output logic [knn_pkg::DIST_W-1:0]          distance_sq,
    output logic                                found,
    output logic                                overflow,
    output logic                                last
);

    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIMC_W = $clog2(MAX_DIM + 1);
    localparam int KI_W   = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int KC_W   = $clog2(MAX_NEIGHBOURS + 1);
    localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W  = $clog2(MAX_CANDIDATES);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int EXT_W  = (DIFF_W > knn_pkg::SQ_OP_W) ? DIFF_W : knn_pkg::SQ_OP_W + 1;
    localparam int DW     = knn_pkg::DIST_W;

    // configuration
    logic [knn_pkg::DIM_REG_W-1:0] dim_reg, dim_next;
    logic [knn_pkg::K_REG_W-1:0]   k_reg, k_next;
    logic [DIMC_W-1:0]             eff_dim;
    logic [KC_W-1:0]               eff_k;

    // position and running sums
    logic [ADDR_W-1:0] count_reg, count_next;
    logic [DIMC_W-1:0] cnt_inc;
    logic              cnt_wrap;
    logic [DW-1:0]     accum_reg, accum_next;
    logic [CNT_W-1:0]  cand_cnt_reg, cand_cnt_next;
    logic              ovf_reg, ovf_next;
    logic              clear_all;

    // query store
    logic [COORD_BITS-1:0] qmem [MAX_DIM];
    logic [COORD_BITS-1:0] qdata_reg;

    // distance step
    logic [COORD_BITS-1:0]         coord_reg;
    logic                          done_reg;
    logic [DIFF_W-1:0]             diff;
    logic [DIFF_W-1:0]             diff_abs;
    logic [EXT_W-1:0]              abs_ext;
    logic [knn_pkg::SQ_OP_W-1:0]   sq_op;
    logic                          sq_sat;
    logic [DW-1:0]                 sq_c;
    logic [DW-1:0]                 sq_reg;
    logic                          sqsat_reg;
    logic [DW:0]                   acc_sum;
    logic [DW-1:0]                 acc_new;
    logic [DW-1:0]                 ins_dist_reg;

    // nearest list
    logic [DW-1:0]             best_dist_reg  [MAX_NEIGHBOURS];
    logic [DW-1:0]             best_dist_next [MAX_NEIGHBOURS];
    logic [IDX_W-1:0]          best_idx_reg   [MAX_NEIGHBOURS];
    logic [IDX_W-1:0]          best_idx_next  [MAX_NEIGHBOURS];
    logic [MAX_NEIGHBOURS-1:0] best_vld_reg, best_vld_next;
    logic [MAX_NEIGHBOURS-1:0] keep;
    logic [MAX_NEIGHBOURS-1:0] slot_on;
    logic [IDX_W-1:0]          ins_idx;

    // report
    logic [KI_W-1:0]              rpt_idx_reg, rpt_idx_next;
    logic                         report_last;
    logic                         out_valid_reg, out_valid_next;
    logic [knn_pkg::RANK_W-1:0]   rank_reg;
    logic [knn_pkg::INDEX_W-1:0]  index_reg;
    logic [DW-1:0]                dist_reg;
    logic                         found_reg;
    logic                         ovf_out_reg;
    logic                         last_reg;
    logic                         sel_vld;

    // clamp register values into the supported range
    always_comb
    begin
        if (dim_reg == '0)
        begin
            eff_dim = DIMC_W'(1);
        end
        else if (32'(dim_reg) > 32'(MAX_DIM))
        begin
            eff_dim = DIMC_W'(MAX_DIM);
        end
        else
        begin
            eff_dim = DIMC_W'(dim_reg);
        end

        if (k_reg == '0)
        begin
            eff_k = KC_W'(1);
        end
        else if (32'(k_reg) > 32'(MAX_NEIGHBOURS))
        begin
            eff_k = KC_W'(MAX_NEIGHBOURS);
        end
        else
        begin
            eff_k = KC_W'(k_reg);
        end
    end

    assign cnt_inc     = DIMC_W'(count_reg) + DIMC_W'(1);
    assign cnt_wrap    = (cnt_inc >= eff_dim);
    assign report_last = ((KC_W'(rpt_idx_reg) + KC_W'(1)) == eff_k);
    assign clear_all   = cmd.report_load && report_last;
    assign ins_idx     = IDX_W'(cand_cnt_reg);

    // |x - q|, saturated once the square would not fit the distance width
    always_comb
    begin
        diff     = {coord_reg[COORD_BITS-1], coord_reg} - {qdata_reg[COORD_BITS-1], qdata_reg};
        diff_abs = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        abs_ext  = EXT_W'(diff_abs);
        sq_sat   = |abs_ext[EXT_W-1:knn_pkg::SQ_OP_W];
        sq_op    = abs_ext[knn_pkg::SQ_OP_W-1:0];
        sq_c     = sq_op * sq_op;
    end

    always_comb
    begin
        acc_sum = {1'b0, accum_reg} + {1'b0, sq_reg};
        if (sqsat_reg || (acc_sum > {1'b0, knn_pkg::DIST_SAT}))
        begin
            acc_new = knn_pkg::DIST_SAT;
        end
        else
        begin
            acc_new = acc_sum[DW-1:0];
        end
    end

    // control state next values
    always_comb
    begin
        dim_next       = dim_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        accum_next     = accum_reg;
        cand_cnt_next  = cand_cnt_reg;
        ovf_next       = ovf_reg;
        rpt_idx_next   = rpt_idx_reg;
        out_valid_next = out_valid_reg;

        if (cfg_write_en)
        begin
            unique case (cfg_index)
                knn_pkg::CFG_DIMENSION:  dim_next = cfg_data[knn_pkg::DIM_REG_W-1:0];
                knn_pkg::CFG_NEIGHBOURS: k_next   = cfg_data[knn_pkg::K_REG_W-1:0];
            endcase
        end

        if (cmd.query_wr || cmd.cand_rd)
        begin
            count_next = cnt_wrap ? '0 : ADDR_W'(cnt_inc);
        end

        // a query coordinate drops any partial candidate sum
        if (cmd.query_wr)
        begin
            accum_next = '0;
        end

        if (cmd.accum)
        begin
            if (done_reg)
            begin
                accum_next = '0;
                if (status.cand_full)
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                accum_next = acc_new;
            end
        end

        if (cmd.insert)
        begin
            cand_cnt_next = cand_cnt_reg + CNT_W'(1);
        end

        if (cmd.report_load)
        begin
            out_valid_next = 1'b1;
            rpt_idx_next   = report_last ? '0 : rpt_idx_reg + KI_W'(1);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (clear_all)
        begin
            count_next    = '0;
            accum_next    = '0;
            cand_cnt_next = '0;
            ovf_next      = 1'b0;
        end
    end

    // parallel sorted insertion: keep is a prefix, the new entry goes at its end
    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        best_vld_next  = best_vld_reg;

        for (int i = 0; i < MAX_NEIGHBOURS; i++)
        begin
            keep[i]    = best_vld_reg[i] && (best_dist_reg[i] <= ins_dist_reg);
            slot_on[i] = (KC_W'(i) < eff_k);
        end

        if (cmd.insert)
        begin
            if (slot_on[0] && !keep[0])
            begin
                best_dist_next[0] = ins_dist_reg;
                best_idx_next[0]  = ins_idx;
                best_vld_next[0]  = 1'b1;
            end
            for (int i = 1; i < MAX_NEIGHBOURS; i++)
            begin
                if (slot_on[i] && !keep[i])
                begin
                    if (keep[i-1])
                    begin
                        best_dist_next[i] = ins_dist_reg;
                        best_idx_next[i]  = ins_idx;
                        best_vld_next[i]  = 1'b1;
                    end
                    else
                    begin
                        best_dist_next[i] = best_dist_reg[i-1];
                        best_idx_next[i]  = best_idx_reg[i-1];
                        best_vld_next[i]  = best_vld_reg[i-1];
                    end
                end
            end
        end

        if (clear_all)
        begin
            best_vld_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg       <= knn_pkg::DIM_RESET;
            k_reg         <= knn_pkg::K_RESET;
            count_reg     <= '0;
            accum_reg     <= '0;
            cand_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            best_vld_reg  <= '0;
            rpt_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dim_reg       <= dim_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            accum_reg     <= accum_next;
            cand_cnt_reg  <= cand_cnt_next;
            ovf_reg       <= ovf_next;
            best_vld_reg  <= best_vld_next;
            rpt_idx_reg   <= rpt_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // query memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.query_wr)
        begin
            qmem[count_reg] <= coord_value;
        end
        if (cmd.cand_rd)
        begin
            qdata_reg <= qmem[count_reg];
        end
    end

    assign sel_vld = best_vld_reg[rpt_idx_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.cand_rd)
        begin
            coord_reg <= coord_value;
            done_reg  <= cnt_wrap;
        end
        if (cmd.square)
        begin
            sq_reg    <= sq_c;
            sqsat_reg <= sq_sat;
        end
        if (cmd.accum && done_reg)
        begin
            ins_dist_reg <= acc_new;
        end
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        if (cmd.report_load)
        begin
            rank_reg    <= knn_pkg::RANK_W'(rpt_idx_reg);
            index_reg   <= sel_vld ? knn_pkg::INDEX_W'(best_idx_reg[rpt_idx_reg]) : '0;
            dist_reg    <= sel_vld ? best_dist_reg[rpt_idx_reg] : '0;
            found_reg   <= sel_vld;
            ovf_out_reg <= ovf_reg;
            last_reg    <= report_last;
        end
    end

    assign status.point_done  = done_reg;
    assign status.cand_full   = (cand_cnt_reg >= CNT_W'(MAX_CANDIDATES));
    assign status.report_last = report_last;
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign rank            = rank_reg;
    assign neighbour_index = index_reg;
    assign distance_sq     = dist_reg;
    assign found           = found_reg;
    assign overflow        = ovf_out_reg;
    assign last            = last_reg;

endmodule

>>> bench/knn_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// knn_result_checker
// Follows the configuration port and both channels of the k-nearest search
// block, keeps its own copy of the query, the running distance and the
// sorted neighbour list, and compares every reported beat with the
// neighbour it expects next.
// ---------------------------------------------------------------------------
module knn_result_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [knn_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic [knn_pkg::REQ_W-1:0]               req_type,
    input  logic signed [knn_pkg::DEF_COORD_BITS-1:0] coord_value,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic [knn_pkg::RANK_W-1:0]              rank,
    input  logic [knn_pkg::INDEX_W-1:0]             neighbour_index,
    input  logic [knn_pkg::DIST_W-1:0]              distance_sq,
    input  logic                                    found,
    input  logic                                    overflow,
    input  logic                                    last,
    output int                                      mismatches,
    output int                                      outstanding
);

    localparam int              NDIM       = knn_pkg::DEF_MAX_DIM;
    localparam int              NK         = knn_pkg::DEF_MAX_NEIGHBOURS;
    localparam int unsigned     CAND_LIMIT = knn_pkg::DEF_MAX_CANDIDATES;
    localparam int              DW         = knn_pkg::DIST_W;
    localparam int              CW         = knn_pkg::DEF_COORD_BITS;
    localparam int              IW         = knn_pkg::INDEX_W;
    localparam longint unsigned DIST_CAP   = (64'd1 << DW) - 64'd1;
    localparam longint unsigned DIST_NONE  = (64'd1 << (DW + 1)) - 64'd1;
    localparam longint unsigned MAG_CAP    = 64'd1 << knn_pkg::SQ_OP_W;

    typedef struct packed {
        logic [knn_pkg::RANK_W-1:0] rank;
        logic [IW-1:0]              idx;
        logic [DW-1:0]              dist_sq;
        logic                       found;
        logic                       ovf;
        logic                       last;
    } neighbour_beat_t;

    logic [knn_pkg::DIM_REG_W-1:0]    dim_reg;
    logic [knn_pkg::K_REG_W-1:0]      k_reg;
    logic signed [CW-1:0]             query_pt [NDIM];
    int unsigned                      coord_pos;
    longint unsigned                  partial_dist;
    int unsigned                      cand_seen;
    longint unsigned                  near_dist [NK];
    logic [IW-1:0]                    near_idx [NK];
    bit                               near_used [NK];
    bit                               limit_hit;
    neighbour_beat_t                  expected_neighbours [$];

    function automatic int unsigned dim_in_use();
        if (dim_reg == 0)
            return 1;
        if (dim_reg > NDIM)
            return NDIM;
        return dim_reg;
    endfunction

    function automatic int unsigned k_in_use();
        if (k_reg == 0)
            return 1;
        if (k_reg > NK)
            return NK;
        return k_reg;
    endfunction

    function automatic void clear_list();
        for (int i = 0; i < NK; i++)
        begin
            near_dist[i] = DIST_NONE;
            near_idx[i]  = '0;
            near_used[i] = 1'b0;
        end
    endfunction

    // ties stay behind the earlier candidate
    function automatic void insert_nearest(input longint unsigned cand_dist,
                                           input int unsigned idx);
        int unsigned k;
        int unsigned p;
        k = k_in_use();
        p = 0;
        while (p < k && near_used[p] && near_dist[p] <= cand_dist)
            p++;
        if (p >= k)
            return;
        for (int unsigned i = k - 1; i > p; i--)
        begin
            near_dist[i] = near_dist[i-1];
            near_idx[i]  = near_idx[i-1];
            near_used[i] = near_used[i-1];
        end
        near_dist[p] = cand_dist;
        near_idx[p]  = idx[IW-1:0];
        near_used[p] = 1'b1;
    endfunction

    function automatic void report_list();
        neighbour_beat_t beat;
        int unsigned     k;
        k = k_in_use();
        for (int unsigned i = 0; i < k; i++)
        begin
            beat.rank    = i[knn_pkg::RANK_W-1:0];
            beat.idx     = near_used[i] ? near_idx[i] : '0;
            beat.dist_sq = near_used[i] ? near_dist[i][DW-1:0] : '0;
            beat.found   = near_used[i];
            beat.ovf     = limit_hit;
            beat.last    = (i + 1 == k);
            expected_neighbours.push_back(beat);
        end
        clear_list();
        cand_seen    = 0;
        limit_hit    = 1'b0;
        coord_pos    = 0;
        partial_dist = 0;
    endfunction

    function automatic void take_coord(input logic [knn_pkg::REQ_W-1:0] req,
                                       input logic signed [CW-1:0] value);
        int unsigned     pos;
        longint          diff;
        longint unsigned mag;
        longint unsigned sq;
        pos = coord_pos % NDIM;
        case (req)
            knn_pkg::REQ_QUERY:
            begin
                query_pt[pos] = value;
                partial_dist  = 0;
                coord_pos++;
                if (coord_pos >= dim_in_use())
                    coord_pos = 0;
            end
            knn_pkg::REQ_CAND:
            begin
                diff = longint'(value) - longint'(query_pt[pos]);
                if (diff < 0)
                    mag = -diff;
                else
                    mag = diff;
                sq = (mag > MAG_CAP) ? DIST_CAP : mag * mag;
                if (sq >= DIST_CAP || partial_dist > DIST_CAP - sq)
                    partial_dist = DIST_CAP;
                else
                    partial_dist = partial_dist + sq;
                coord_pos++;
                if (coord_pos >= dim_in_use())
                begin
                    coord_pos = 0;
                    if (cand_seen >= CAND_LIMIT)
                        limit_hit = 1'b1;
                    else
                    begin
                        insert_nearest(partial_dist, cand_seen);
                        cand_seen++;
                    end
                    partial_dist = 0;
                end
            end
            knn_pkg::REQ_FINISH:
                report_list();
            default:
                ;
        endcase
    endfunction

    function automatic void check_beat();
        neighbour_beat_t got;
        neighbour_beat_t want;
        got = {rank, neighbour_index, distance_sq, found, overflow, last};
        if (expected_neighbours.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat: rank %0d index %0d dist %0d found %b ovf %b last %b",
                         got.rank, got.idx, got.dist_sq, got.found, got.ovf, got.last);
            return;
        end
        want = expected_neighbours.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("beat mismatch, expected: rank %0d index %0d dist %0d found %b ovf %b last %b",
                         want.rank, want.idx, want.dist_sq, want.found, want.ovf, want.last);
                $display("                 actual: rank %0d index %0d dist %0d found %b ovf %b last %b",
                         got.rank, got.idx, got.dist_sq, got.found, got.ovf, got.last);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg = knn_pkg::DIM_RESET;
            k_reg   = knn_pkg::K_RESET;
            for (int i = 0; i < NDIM; i++)
                query_pt[i] = '0;
            coord_pos    = 0;
            partial_dist = 0;
            cand_seen    = 0;
            limit_hit    = 1'b0;
            clear_list();
            expected_neighbours.delete();
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    knn_pkg::CFG_DIMENSION:  dim_reg = cfg_data[knn_pkg::DIM_REG_W-1:0];
                    knn_pkg::CFG_NEIGHBOURS: k_reg   = cfg_data[knn_pkg::K_REG_W-1:0];
                    default:                 ;
                endcase
            end
            if (in_valid && !in_stall)
                take_coord(req_type, coord_value);
            if (out_valid && !out_stall)
                check_beat();
            outstanding <= expected_neighbours.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives query and candidate coordinates into the k-nearest search block
// under random bursts and output stalls: a directed pass over the extremes
// and corner cases, then random searches over many settings. The checker
// beside the block judges every reported beat.
// ---------------------------------------------------------------------------
module tb;

    localparam int                      CW          = knn_pkg::DEF_COORD_BITS;
    localparam int                      DATA_W      = knn_pkg::CFG_DATA_W;
    localparam logic [knn_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic signed [CW-1:0]    COORD_MAX   = 16'sh7FFF;
    localparam logic signed [CW-1:0]    COORD_MIN   = 16'sh8000;
    localparam int                      ITEM_TARGET = 260;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              cfg_write_en = 1'b0;
    logic [knn_pkg::CFG_IDX_W-1:0]     cfg_index    = knn_pkg::CFG_DIMENSION;
    logic [DATA_W-1:0]                 cfg_data     = '0;
    logic                              in_valid     = 1'b0;
    logic                              in_stall;
    logic [knn_pkg::REQ_W-1:0]         req_type     = knn_pkg::REQ_QUERY;
    logic signed [CW-1:0]              coord_value  = '0;
    logic                              out_valid;
    logic                              out_stall    = 1'b0;
    logic [knn_pkg::RANK_W-1:0]        rank;
    logic [knn_pkg::INDEX_W-1:0]       neighbour_index;
    logic [knn_pkg::DIST_W-1:0]        distance_sq;
    logic                              found;
    logic                              overflow;
    logic                              last;
    int                                mismatches;
    int                                outstanding;

    stall_mode_t stall_mode = STALL_NONE;
    int          stall_hold = 0;
    bit          gaps_on    = 1'b1;
    int          burst_left = 0;
    int          beats_sent = 0;
    int unsigned dim_now    = 2;

    knn_top_k_search DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .coord_value     (coord_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rank            (rank),
        .neighbour_index (neighbour_index),
        .distance_sq     (distance_sq),
        .found           (found),
        .overflow        (overflow),
        .last            (last)
    );

    knn_result_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .coord_value     (coord_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rank            (rank),
        .neighbour_index (neighbour_index),
        .distance_sq     (distance_sq),
        .found           (found),
        .overflow        (overflow),
        .last            (last),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver: switches between stall patterns after a random hold
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_hold <= $urandom_range(8, 80);
        end
        else
            stall_hold <= stall_hold - 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ~out_stall;
        endcase
    end

    function automatic int unsigned dim_in_use(input int unsigned d);
        if (d == 0)
            return 1;
        if (d > knn_pkg::DEF_MAX_DIM)
            return knn_pkg::DEF_MAX_DIM;
        return d;
    endfunction

    function automatic logic signed [CW-1:0] pick_coord(input bit narrow);
        if (narrow)
            return CW'($urandom_range(0, 4) - 2);
        return CW'($urandom);
    endfunction

    // one beat; valid stays high into the next call unless a gap is due
    task automatic send_beat(input logic [knn_pkg::REQ_W-1:0] req,
                             input logic signed [CW-1:0] value);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        coord_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (req != REQ_UNUSED)
            beats_sent++;
    endtask

    // wait out every report plus the pipeline of the last coordinate
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] dim, input logic [DATA_W-1:0] nbr);
        cfg_write_en <= 1'b1;
        cfg_index    <= knn_pkg::CFG_DIMENSION;
        cfg_data     <= dim;
        @(posedge clk);
        cfg_index    <= knn_pkg::CFG_NEIGHBOURS;
        cfg_data     <= nbr;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        dim_now = dim_in_use(dim);
    endtask

    initial
    begin
        int                   dim_pick;
        int                   k_pick;
        int                   n_pts;
        bit                   narrow;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: two coordinates per point, one neighbour
        send_beat(knn_pkg::REQ_QUERY, COORD_MAX);
        send_beat(knn_pkg::REQ_QUERY, COORD_MIN);
        send_beat(knn_pkg::REQ_CAND, COORD_MIN);
        send_beat(knn_pkg::REQ_CAND, COORD_MAX);
        send_beat(knn_pkg::REQ_CAND, COORD_MAX);
        send_beat(knn_pkg::REQ_CAND, COORD_MIN);
        send_beat(knn_pkg::REQ_FINISH, '0);
        settle();

        // fill every query entry; an empty search reports only empty slots
        set_config(DATA_W'(knn_pkg::DEF_MAX_DIM), DATA_W'(knn_pkg::DEF_MAX_NEIGHBOURS));
        for (int i = 0; i < knn_pkg::DEF_MAX_DIM; i++)
            send_beat(knn_pkg::REQ_QUERY, i[0] ? COORD_MAX : COORD_MIN);
        send_beat(knn_pkg::REQ_FINISH, '0);
        settle();

        // out-of-range settings clamp; farthest possible point, then an exact match
        set_config(7'd127, 7'd31);
        for (int i = 0; i < knn_pkg::DEF_MAX_DIM; i++)
            send_beat(knn_pkg::REQ_CAND, i[0] ? COORD_MIN : COORD_MAX);
        for (int i = 0; i < knn_pkg::DEF_MAX_DIM; i++)
            send_beat(knn_pkg::REQ_CAND, i[0] ? COORD_MAX : COORD_MIN);
        send_beat(knn_pkg::REQ_FINISH, '0);
        settle();

        // zero settings act as one; equal distances keep the earlier candidate
        set_config(7'd0, 7'd0);
        send_beat(knn_pkg::REQ_CAND, 16'sd5);
        send_beat(knn_pkg::REQ_CAND, 16'sd5);
        send_beat(knn_pkg::REQ_FINISH, '0);
        settle();

        set_config(7'd3, 7'd4);
        send_beat(knn_pkg::REQ_CAND, COORD_MAX);
        send_beat(knn_pkg::REQ_QUERY, 16'sd100);    // partial sum dropped, position moves on
        send_beat(knn_pkg::REQ_CAND, -16'sd7);
        send_beat(knn_pkg::REQ_CAND, 16'sd1);
        send_beat(knn_pkg::REQ_CAND, 16'sd2);
        settle();

        // dimension drops to one: the next coordinate closes a point;
        // neighbour count shrinks with the search still open
        set_config(7'd1, 7'd2);
        send_beat(REQ_UNUSED, 16'sh5A5A);
        send_beat(knn_pkg::REQ_CAND, 16'sd3);
        send_beat(knn_pkg::REQ_CAND, COORD_MIN);
        send_beat(knn_pkg::REQ_FINISH, COORD_MAX);
        settle();

        while (beats_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 19))
                0:          dim_pick = knn_pkg::DEF_MAX_DIM;
                1:          dim_pick = $urandom_range(0, 127);
                2, 3, 4, 5: dim_pick = $urandom_range(5, 12);
                default:    dim_pick = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 7))
                0:       k_pick = 0;
                1:       k_pick = knn_pkg::DEF_MAX_NEIGHBOURS;
                2:       k_pick = $urandom_range(17, 31);
                default: k_pick = $urandom_range(1, 8);
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            set_config(DATA_W'(dim_pick), DATA_W'(k_pick));
            repeat ($urandom_range(1, 3))
            begin
                narrow = ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 2) == 0)
                    for (int i = 0; i < dim_now; i++)
                        send_beat(knn_pkg::REQ_QUERY, pick_coord(narrow));
                n_pts = (dim_now > 8) ? $urandom_range(0, 3) : $urandom_range(0, 20);
                repeat (n_pts)
                begin
                    for (int i = 0; i < dim_now; i++)
                    begin
                        if ($urandom_range(0, 40) == 0)
                        begin
                            case ($urandom_range(0, 2))
                                0:       send_beat(REQ_UNUSED, pick_coord(1'b0));
                                1:       send_beat(knn_pkg::REQ_QUERY, pick_coord(narrow));
                                default: send_beat(knn_pkg::REQ_FINISH, pick_coord(1'b0));
                            endcase
                        end
                        send_beat(knn_pkg::REQ_CAND, pick_coord(narrow));
                    end
                end
                // now and then leave the search open across a settings change
                if ($urandom_range(0, 7) != 0)
                    send_beat(knn_pkg::REQ_FINISH, pick_coord(1'b0));
            end
            settle();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
